### rtl/core/bwe_pkg.sv
// ----------------------------------------------------------------------------
// bwe_pkg: Breit-Wigner evaluator shared types and constants
// Item structs, datapath command/status structs, state and op enums, and the
// fixed physics constants in raw Q8.24 / Q48 units.
// ----------------------------------------------------------------------------
`default_nettype none

package bwe_pkg;

  localparam int unsigned MASS_W  = 32;   // Q8.24 mass width
  localparam int unsigned WIDE_W  = 128;  // working width of long products
  localparam int unsigned ROOT_W  = 64;   // momentum root width
  localparam int unsigned RATIO_W = 48;   // momentum ratio width, Q24
  localparam int unsigned GW_W    = 40;   // running width, Q24
  localparam int unsigned FRAC_BITS = 24;
  localparam int unsigned NUM_SHIFT = 2 * FRAC_BITS - 14;
  localparam int unsigned OUT_W   = 32;

  // nucleon and pion masses, Q8.24
  localparam logic [WIDE_W-1:0] MN_RAW  = 128'd15752442;
  localparam logic [WIDE_W-1:0] MPI_RAW = 128'd2264532;
  // mN^2 + mPi^2 (Q48)
  localparam logic [63:0] MASS_SUM_SQ =
      64'(MN_RAW * MN_RAW + MPI_RAW * MPI_RAW);
  // 4 mN^2 mPi^2 (Q96)
  localparam logic [WIDE_W-1:0] MASS_PROD_SQ4 =
      (MN_RAW * MN_RAW) * (MPI_RAW * MPI_RAW) * 128'd4;
  // 1/(2 pi) in Q32
  localparam logic [31:0] INV2PI_Q32 = 32'd683565276;

  localparam logic [RATIO_W-1:0] RATIO_CAP = '1;
  localparam logic [GW_W-1:0]    WIDTH_CAP = '1;
  localparam logic [OUT_W-1:0]   OUT_MAX   = '1;

  // configuration register indexes
  localparam logic [1:0] CFG_RES_MASS   = 2'd0;
  localparam logic [1:0] CFG_BASE_WIDTH = 2'd1;
  localparam logic [1:0] CFG_BW_NORM    = 2'd2;
  localparam logic [1:0] CFG_ORBITAL_L  = 2'd3;

  // configuration reset values
  localparam logic [MASS_W-1:0] RST_RES_MASS   = 32'd20669530;
  localparam logic [MASS_W-1:0] RST_BASE_WIDTH = 32'd2013266;
  localparam logic [MASS_W-1:0] RST_BW_NORM    = 32'd16777216;
  localparam logic [2:0]        RST_ORBITAL_L  = 3'd1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SAT     = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  typedef struct packed {
    logic              func;
    logic [MASS_W-1:0] w_mass;
  } bwe_in_t;

  typedef struct packed {
    logic [OUT_W-1:0] bw_value;
    logic [1:0]       status;
  } bwe_out_t;

  // shared iterative unit operations
  typedef enum logic [1:0] {
    AR_MUL,
    AR_DIV,
    AR_SQRT
  } arith_op_e;

  // datapath commands
  typedef enum logic [4:0] {
    DP_NONE,
    DP_LOAD,
    DP_MUL_XX,
    DP_ABS_A,
    DP_MUL_TT,
    DP_SUB_B,
    DP_SQRT,
    DP_SAVE_ROOT,
    DP_MUL_SWM,
    DP_SAVE_N,
    DP_MUL_SMW,
    DP_DIV_RATIO,
    DP_SAVE_RATIO,
    DP_MUL_GR,
    DP_SAVE_G,
    DP_MUL_DD,
    DP_SAVE_D2,
    DP_MUL_GG,
    DP_ADD_S,
    DP_MUL_DEN,
    DP_SAVE_DEN,
    DP_MUL_NUM,
    DP_DIV_Q,
    DP_SAVE_Q,
    DP_SET_INV,
    DP_EMIT
  } dp_op_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_RT_SQ,
    S_RT_ABS,
    S_RT_SQ2,
    S_RT_SUB,
    S_RT_SQRT,
    S_RT_SAVE,
    S_RT_CHK,
    S_RAT_M1,
    S_RAT_N,
    S_RAT_M2,
    S_RAT_DIV,
    S_RAT_SAVE,
    S_G_MUL,
    S_G_SAVE,
    S_F_DD,
    S_F_D2,
    S_F_GG,
    S_F_ADD,
    S_F_DEN,
    S_F_SDEN,
    S_F_NUM,
    S_F_DIV,
    S_F_SAVE,
    S_INV,
    S_EMIT,
    S_WAIT
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e op;
    logic   sel_w;   // root pass works on W (1) or on the resonance mass (0)
  } dp_cmd_t;

  typedef struct packed {
    logic       arith_busy;
    logic       in_invalid;
    logic       func;
    logic       sm_zero;
    logic       den_zero;
    logic [2:0] orbital_l;
  } dp_stat_t;

endpackage

`default_nettype wire

### rtl/core/bwe_arith.sv
// ----------------------------------------------------------------------------
// bwe_arith: shared iterative arithmetic unit
// Radix-2 shift-add multiply (64 steps), restoring divide (128 steps) and
// digit-by-digit integer square root (64 steps), one step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bwe_arith (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire bwe_pkg::arith_op_e         op_i,
  input  wire logic [bwe_pkg::WIDE_W-1:0] a_i,
  input  wire logic [bwe_pkg::WIDE_W-1:0] b_i,
  output logic                            busy_o,
  output logic [bwe_pkg::WIDE_W-1:0]      res_o
);
  import bwe_pkg::*;

  arith_op_e          op_q;
  logic               busy_q;
  logic [6:0]         cnt_q;
  logic [WIDE_W-1:0]  r_q, r_d;   // product / remainder
  logic [WIDE_W-1:0]  x_q, x_d;   // multiplicand / dividend-quotient / radicand
  logic [WIDE_W-1:0]  y_q, y_d;   // multiplier / divisor
  logic [ROOT_W-1:0]  z_q, z_d;   // root
  logic               last;

  assign last = (op_q == AR_DIV) ? (cnt_q == 7'd127) : (cnt_q == 7'd63);

  // one iteration step
  always_comb begin
    logic [WIDE_W:0] rem_sh;
    logic [WIDE_W:0] div_diff;
    logic [67:0]     sq_rem;
    logic [67:0]     sq_trial;
    rem_sh   = {r_q, x_q[WIDE_W-1]};
    div_diff = rem_sh - {1'b0, y_q};
    sq_rem   = {r_q[65:0], x_q[WIDE_W-1 -: 2]};
    sq_trial = {2'b00, z_q, 2'b01};
    r_d = r_q;
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    case (op_q)
      AR_MUL: begin
        if (y_q[0]) begin
          r_d = r_q + x_q;
        end
        x_d = x_q << 1;
        y_d = y_q >> 1;
      end
      AR_DIV: begin
        if (rem_sh >= {1'b0, y_q}) begin
          r_d = div_diff[WIDE_W-1:0];
          x_d = {x_q[WIDE_W-2:0], 1'b1};
        end else begin
          r_d = rem_sh[WIDE_W-1:0];
          x_d = {x_q[WIDE_W-2:0], 1'b0};
        end
      end
      AR_SQRT: begin
        if (sq_rem >= sq_trial) begin
          r_d = {60'd0, sq_rem - sq_trial};
          z_d = {z_q[ROOT_W-2:0], 1'b1};
        end else begin
          r_d = {60'd0, sq_rem};
          z_d = {z_q[ROOT_W-2:0], 1'b0};
        end
        x_d = x_q << 2;
      end
      default: begin
        r_d = r_q;
      end
    endcase
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= AR_MUL;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
      op_q   <= op_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 7'd1;
      if (last) begin
        busy_q <= 1'b0;
      end
    end
  end

  // operand and result registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q <= '0;
      x_q <= a_i;
      y_q <= b_i;
      z_q <= '0;
    end else if (busy_q) begin
      r_q <= r_d;
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign busy_o = busy_q;

  always_comb begin
    case (op_q)
      AR_MUL:  res_o = r_q;
      AR_DIV:  res_o = x_q;
      AR_SQRT: res_o = {64'd0, z_q};
      default: res_o = r_q;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/bwe_datapath.sv
// ----------------------------------------------------------------------------
// bwe_datapath: configuration registers, working registers and output stage
// Executes one command per cycle from the controller; long operations run on
// the shared iterative unit.
// ----------------------------------------------------------------------------
`default_nettype none

module bwe_datapath (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [1:0]                 cfg_index_i,
  input  wire logic [bwe_pkg::MASS_W-1:0] cfg_data_i,
  input  wire bwe_pkg::bwe_in_t           in_item_i,
  input  wire bwe_pkg::dp_cmd_t           cmd_i,
  output bwe_pkg::dp_stat_t               stat_o,
  output bwe_pkg::bwe_out_t               out_item_o
);
  import bwe_pkg::*;

  // configuration
  logic [MASS_W-1:0] res_mass_q, base_width_q, bw_norm_q;
  logic [2:0]        orbital_l_q;

  // working registers
  logic              func_q;
  logic [MASS_W-1:0] w_q;
  logic [63:0]       tmp_q;
  logic              zflag_q;
  logic [ROOT_W-1:0] sm_q, sw_q;
  logic [RATIO_W-1:0] ratio_q;
  logic [GW_W-1:0]   g_q;
  logic [WIDE_W-1:0] s_q;
  logic              sat_q;
  logic [OUT_W-1:0]  val_q;
  logic [1:0]        stat_q;
  bwe_out_t          out_q;

  // shared unit
  logic              ar_start;
  arith_op_e         ar_op;
  logic [WIDE_W-1:0] ar_a, ar_b, ar_res;
  logic              ar_busy;

  logic [MASS_W-1:0] x_sel;
  logic [MASS_W-1:0] d_abs;
  logic [63:0]       sq_lo;

  assign x_sel = cmd_i.sel_w ? w_q : res_mass_q;
  assign d_abs = (w_q >= res_mass_q) ? (w_q - res_mass_q) : (res_mass_q - w_q);
  assign sq_lo = ar_res[63:0];

  bwe_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(ar_start),
    .op_i   (ar_op),
    .a_i    (ar_a),
    .b_i    (ar_b),
    .busy_o (ar_busy),
    .res_o  (ar_res)
  );

  // operand selection for the shared unit
  always_comb begin
    ar_start = 1'b1;
    ar_op    = AR_MUL;
    ar_a     = '0;
    ar_b     = '0;
    case (cmd_i.op)
      DP_MUL_XX: begin
        ar_a = {96'd0, x_sel};
        ar_b = {96'd0, x_sel};
      end
      DP_MUL_TT: begin
        ar_a = {64'd0, tmp_q};
        ar_b = {64'd0, tmp_q};
      end
      DP_SQRT: begin
        ar_op = AR_SQRT;
        ar_a  = s_q;
      end
      DP_MUL_SWM: begin
        ar_a = {64'd0, sw_q};
        ar_b = {96'd0, res_mass_q};
      end
      DP_MUL_SMW: begin
        ar_a = {64'd0, sm_q};
        ar_b = {96'd0, w_q};
      end
      DP_DIV_RATIO: begin
        ar_op = AR_DIV;
        ar_a  = s_q;
        ar_b  = ar_res;
      end
      DP_MUL_GR: begin
        ar_a = {80'd0, ratio_q};
        ar_b = {88'd0, g_q};
      end
      DP_MUL_DD: begin
        ar_a = {96'd0, d_abs};
        ar_b = {96'd0, d_abs};
      end
      DP_MUL_GG: begin
        ar_a = {88'd0, g_q};
        ar_b = {88'd0, g_q};
      end
      DP_MUL_DEN: begin
        ar_a = s_q;
        ar_b = {96'd0, bw_norm_q};
      end
      DP_MUL_NUM: begin
        ar_a = {96'd0, INV2PI_Q32};
        ar_b = {88'd0, g_q};
      end
      DP_DIV_Q: begin
        ar_op = AR_DIV;
        ar_a  = ar_res << NUM_SHIFT;
        ar_b  = s_q;
      end
      default: begin
        ar_start = 1'b0;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_mass_q   <= RST_RES_MASS;
      base_width_q <= RST_BASE_WIDTH;
      bw_norm_q    <= RST_BW_NORM;
      orbital_l_q  <= RST_ORBITAL_L;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_RES_MASS:   res_mass_q   <= cfg_data_i;
        CFG_BASE_WIDTH: base_width_q <= cfg_data_i;
        CFG_BW_NORM:    bw_norm_q    <= cfg_data_i;
        CFG_ORBITAL_L:  orbital_l_q  <= cfg_data_i[2:0];
        default:        orbital_l_q  <= orbital_l_q;
      endcase
    end
  end

  // working registers, one command per cycle
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_LOAD: begin
        func_q <= in_item_i.func;
        w_q    <= in_item_i.w_mass;
        g_q    <= {8'd0, base_width_q};
        sat_q  <= 1'b0;
      end
      DP_ABS_A: begin
        tmp_q <= (sq_lo >= MASS_SUM_SQ) ? (sq_lo - MASS_SUM_SQ) : (MASS_SUM_SQ - sq_lo);
      end
      DP_SUB_B: begin
        zflag_q <= (ar_res <= MASS_PROD_SQ4);
        s_q     <= ar_res - MASS_PROD_SQ4;
      end
      DP_SAVE_ROOT: begin
        if (cmd_i.sel_w) begin
          sw_q <= zflag_q ? '0 : ar_res[ROOT_W-1:0];
        end else begin
          sm_q <= zflag_q ? '0 : ar_res[ROOT_W-1:0];
        end
      end
      DP_SAVE_N: begin
        s_q <= ar_res << FRAC_BITS;
      end
      DP_SAVE_RATIO: begin
        if (|ar_res[WIDE_W-1:RATIO_W]) begin
          ratio_q <= RATIO_CAP;
          sat_q   <= 1'b1;
        end else begin
          ratio_q <= ar_res[RATIO_W-1:0];
        end
      end
      DP_SAVE_G: begin
        // clamp floor(G*R / 2^24) to the width cap
        if (|ar_res[WIDE_W-1:GW_W+FRAC_BITS]) begin
          g_q   <= WIDTH_CAP;
          sat_q <= 1'b1;
        end else begin
          g_q <= ar_res[GW_W+FRAC_BITS-1:FRAC_BITS];
        end
      end
      DP_SAVE_D2: begin
        s_q <= ar_res << 2;
      end
      DP_ADD_S: begin
        s_q <= s_q + ar_res;
      end
      DP_SAVE_DEN: begin
        s_q <= ar_res;
      end
      DP_SAVE_Q: begin
        if (|ar_res[WIDE_W-1:OUT_W]) begin
          val_q  <= OUT_MAX;
          stat_q <= ST_SAT;
        end else begin
          val_q  <= ar_res[OUT_W-1:0];
          stat_q <= sat_q ? ST_SAT : ST_OK;
        end
      end
      DP_SET_INV: begin
        val_q  <= '0;
        stat_q <= ST_INVALID;
      end
      DP_EMIT: begin
        out_q.bw_value <= val_q;
        out_q.status   <= stat_q;
      end
      default: begin
        tmp_q <= tmp_q;
      end
    endcase
  end

  assign out_item_o = out_q;

  // status to the controller
  always_comb begin
    stat_o.arith_busy = ar_busy;
    stat_o.in_invalid = (w_q == '0) || (res_mass_q == '0) ||
                        (base_width_q == '0) || (bw_norm_q == '0);
    stat_o.func       = func_q;
    stat_o.sm_zero    = (sm_q == '0);
    stat_o.den_zero   = (s_q == '0);
    stat_o.orbital_l  = orbital_l_q;
  end

endmodule

`default_nettype wire

### rtl/core/bwe_ctrl.sv
// ----------------------------------------------------------------------------
// bwe_ctrl: sequencing state machine
// Walks each item through its command sequence, waits on the shared unit,
// and hands the finished result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bwe_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              out_stall_i,
  output logic                   out_valid_o,
  input  wire bwe_pkg::dp_stat_t stat_i,
  output bwe_pkg::dp_cmd_t       cmd_o
);
  import bwe_pkg::*;

  ctrl_state_e state_q, state_d;
  ctrl_state_e ret_q, ret_d;
  logic        sel_w_q, sel_w_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        out_valid_q, out_valid_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      sel_w_q     <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      sel_w_q     <= sel_w_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    sel_w_d     = sel_w_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o.op    = DP_NONE;
    cmd_o.sel_w = sel_w_q;
    in_stall_o  = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.op = DP_LOAD;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.in_invalid) begin
          state_d = S_INV;
        end else if (stat_i.func) begin
          sel_w_d = 1'b0;
          state_d = S_RT_SQ;
        end else begin
          state_d = S_F_DD;
        end
      end
      // decay momentum root of the selected mass
      S_RT_SQ: begin
        cmd_o.op = DP_MUL_XX;
        ret_d    = S_RT_ABS;
        state_d  = S_WAIT;
      end
      S_RT_ABS: begin
        cmd_o.op = DP_ABS_A;
        state_d  = S_RT_SQ2;
      end
      S_RT_SQ2: begin
        cmd_o.op = DP_MUL_TT;
        ret_d    = S_RT_SUB;
        state_d  = S_WAIT;
      end
      S_RT_SUB: begin
        cmd_o.op = DP_SUB_B;
        state_d  = S_RT_SQRT;
      end
      S_RT_SQRT: begin
        cmd_o.op = DP_SQRT;
        ret_d    = S_RT_SAVE;
        state_d  = S_WAIT;
      end
      S_RT_SAVE: begin
        cmd_o.op = DP_SAVE_ROOT;
        state_d  = sel_w_q ? S_RAT_M1 : S_RT_CHK;
      end
      S_RT_CHK: begin
        if (stat_i.sm_zero) begin
          state_d = S_INV;
        end else begin
          sel_w_d = 1'b1;
          state_d = S_RT_SQ;
        end
      end
      // momentum ratio
      S_RAT_M1: begin
        cmd_o.op = DP_MUL_SWM;
        ret_d    = S_RAT_N;
        state_d  = S_WAIT;
      end
      S_RAT_N: begin
        cmd_o.op = DP_SAVE_N;
        state_d  = S_RAT_M2;
      end
      S_RAT_M2: begin
        cmd_o.op = DP_MUL_SMW;
        ret_d    = S_RAT_DIV;
        state_d  = S_WAIT;
      end
      S_RAT_DIV: begin
        cmd_o.op = DP_DIV_RATIO;
        ret_d    = S_RAT_SAVE;
        state_d  = S_WAIT;
      end
      S_RAT_SAVE: begin
        cmd_o.op = DP_SAVE_RATIO;
        cnt_d    = {stat_i.orbital_l, 1'b1};
        state_d  = S_G_MUL;
      end
      // running width: 2L+1 scaling steps
      S_G_MUL: begin
        cmd_o.op = DP_MUL_GR;
        ret_d    = S_G_SAVE;
        state_d  = S_WAIT;
      end
      S_G_SAVE: begin
        cmd_o.op = DP_SAVE_G;
        if (cnt_q == 4'd1) begin
          state_d = S_F_DD;
        end else begin
          cnt_d   = cnt_q - 4'd1;
          state_d = S_G_MUL;
        end
      end
      // line shape
      S_F_DD: begin
        cmd_o.op = DP_MUL_DD;
        ret_d    = S_F_D2;
        state_d  = S_WAIT;
      end
      S_F_D2: begin
        cmd_o.op = DP_SAVE_D2;
        state_d  = S_F_GG;
      end
      S_F_GG: begin
        cmd_o.op = DP_MUL_GG;
        ret_d    = S_F_ADD;
        state_d  = S_WAIT;
      end
      S_F_ADD: begin
        cmd_o.op = DP_ADD_S;
        state_d  = S_F_DEN;
      end
      S_F_DEN: begin
        cmd_o.op = DP_MUL_DEN;
        ret_d    = S_F_SDEN;
        state_d  = S_WAIT;
      end
      S_F_SDEN: begin
        cmd_o.op = DP_SAVE_DEN;
        state_d  = S_F_NUM;
      end
      S_F_NUM: begin
        cmd_o.op = DP_MUL_NUM;
        ret_d    = S_F_DIV;
        state_d  = S_WAIT;
      end
      S_F_DIV: begin
        if (stat_i.den_zero) begin
          state_d = S_INV;
        end else begin
          cmd_o.op = DP_DIV_Q;
          ret_d    = S_F_SAVE;
          state_d  = S_WAIT;
        end
      end
      S_F_SAVE: begin
        cmd_o.op = DP_SAVE_Q;
        state_d  = S_EMIT;
      end
      S_INV: begin
        cmd_o.op = DP_SET_INV;
        state_d  = S_EMIT;
      end
      // move result into the output register once it is free
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.op    = DP_EMIT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_WAIT: begin
        if (!stat_i.arith_busy) begin
          state_d = ret_q;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### rtl/core/breit_wigner_evaluator.sv
// ----------------------------------------------------------------------------
// breit_wigner_evaluator: Breit-Wigner line shape, fixed or L-dependent width
// Controller plus datapath around one shared iterative mul/div/sqrt unit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries func and W (Q8.24). One
//   item is taken at a time; in_stall_o stays high until its result has
//   moved into the output register.
//   Output channel (out_valid_o / out_stall_i) carries bw_value (Q16.16) and
//   status. The output register holds a finished item while out_stall_i is
//   high, and the next input item is accepted and worked on meanwhile.
//   Configuration writes (cfg_valid_i, always ready) must go in while idle;
//   the block itself does not enforce this.
// The shared unit runs a multiply in 64 steps, a divide in 128 steps and a
// square root in 64 steps. Work per item:
//   func 0: four multiplies and one divide.
//   func 1: two momentum roots, the ratio divide and 2L+1 width scaling
//   multiplies on top of func 0.
//   Items flagged invalid at the check skip the arithmetic.
// Reset restores the register defaults and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module breit_wigner_evaluator (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [1:0]                 cfg_index_i,
  input  wire logic [bwe_pkg::MASS_W-1:0] cfg_data_i,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire bwe_pkg::bwe_in_t           in_item_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output bwe_pkg::bwe_out_t               out_item_o
);
  import bwe_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  bwe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bwe_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_item_o (out_item_o)
  );

  // an accepted item keeps the input side busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while previous item still in work");

  // shared unit only runs while an item is in work
  a_unit_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.arith_busy |-> in_stall_o)
    else $error("arithmetic unit busy while block idle");

  // invalid results carry a zero value
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status == ST_INVALID) |-> out_item_o.bw_value == '0)
    else $error("invalid result with nonzero value");

  // status code never takes the unused encoding
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.status != 2'd3)
    else $error("unused status code on output");

endmodule

`default_nettype wire

### verif/bwe_line_shape_checker.sv
// ----------------------------------------------------------------------------
// bwe_line_shape_checker: predicts and checks Breit-Wigner evaluator results
// Tracks configuration writes, computes the expected line shape for every
// accepted input item and compares each accepted output item in order.
// ----------------------------------------------------------------------------
`default_nettype none

module bwe_line_shape_checker (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_valid_i,
  input  wire logic                       cfg_ready_i,
  input  wire logic [1:0]                 cfg_index_i,
  input  wire logic [bwe_pkg::MASS_W-1:0] cfg_data_i,
  input  wire logic                       in_valid_i,
  input  wire logic                       in_stall_i,
  input  wire bwe_pkg::bwe_in_t           in_item_i,
  input  wire logic                       out_valid_i,
  input  wire logic                       out_stall_i,
  input  wire bwe_pkg::bwe_out_t          out_item_i,
  output int                              fail_count_o,
  output int                              pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import bwe_pkg::*;

  logic [31:0] mass_q, width_q, norm_q;
  logic [2:0]  orb_l_q;
  bwe_out_t    shape_q[$];

  // N-pi decay momentum numerator root, clamped below threshold
  function automatic logic [63:0] decay_root(logic [31:0] x);
    logic [63:0]  x2, t, r, c;
    logic [127:0] t2, rad;
    x2 = 64'(x) * 64'(x);
    t  = (x2 >= MASS_SUM_SQ) ? x2 - MASS_SUM_SQ : MASS_SUM_SQ - x2;
    t2 = 128'(t) * 128'(t);
    if (t2 <= MASS_PROD_SQ4) return 64'd0;
    rad = t2 - MASS_PROD_SQ4;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (128'(c) * 128'(c) <= rad) r = c;
    end
    return r;
  endfunction

  // expected line shape for one item under the current settings
  function automatic bwe_out_t line_shape(bwe_in_t item);
    bwe_out_t     res;
    logic [63:0]  sm, sw, ratio, g, d;
    logic [127:0] r, p, num, den, q;
    logic         sat;
    res.bw_value = '0;
    res.status   = ST_INVALID;
    sat = 1'b0;
    g = 64'(width_q);
    if (item.w_mass == 0 || mass_q == 0 || width_q == 0 || norm_q == 0) return res;
    if (item.func) begin
      sm = decay_root(mass_q);
      if (sm == 0) return res;
      sw = decay_root(item.w_mass);
      r = ((128'(sw) * 128'(mass_q)) << FRAC_BITS) / (128'(sm) * 128'(item.w_mass));
      if (r > 128'(RATIO_CAP)) begin
        ratio = 64'(RATIO_CAP);
        sat = 1'b1;
      end else begin
        ratio = r[63:0];
      end
      for (int k = 0; k < 2 * int'(orb_l_q) + 1; k++) begin
        p = (128'(g) * 128'(ratio)) >> FRAC_BITS;
        if (p > 128'(WIDTH_CAP)) begin
          g = 64'(WIDTH_CAP);
          sat = 1'b1;
        end else begin
          g = p[63:0];
        end
      end
    end
    d = (item.w_mass >= mass_q) ? 64'(item.w_mass - mass_q) : 64'(mass_q - item.w_mass);
    num = (128'(INV2PI_Q32) * 128'(g)) << NUM_SHIFT;
    den = (((128'(d) * 128'(d)) << 2) + 128'(g) * 128'(g)) * 128'(norm_q);
    if (den == 0) return res;
    q = num / den;
    if (q > 128'(OUT_MAX)) begin
      res.bw_value = OUT_MAX;
      sat = 1'b1;
    end else begin
      res.bw_value = q[31:0];
    end
    res.status = sat ? ST_SAT : ST_OK;
    return res;
  endfunction

  assign pending_o = shape_q.size();

  // register shadow, prediction and comparison
  always @(posedge clk_i or negedge rst_ni) begin
    bwe_out_t exp_item;
    if (!rst_ni) begin
      mass_q  <= RST_RES_MASS;
      width_q <= RST_BASE_WIDTH;
      norm_q  <= RST_BW_NORM;
      orb_l_q <= RST_ORBITAL_L;
      fail_count_o = 0;
      shape_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i) shape_q.push_back(line_shape(in_item_i));
      if (out_valid_i && !out_stall_i) begin
        if (shape_q.size() == 0) begin
          $error("unexpected item: bw_value %0h status %0d",
                 out_item_i.bw_value, out_item_i.status);
          fail_count_o++;
        end else begin
          exp_item = shape_q.pop_front();
          if (out_item_i.bw_value !== exp_item.bw_value) begin
            $error("bw_value: expected %0h actual %0h",
                   exp_item.bw_value, out_item_i.bw_value);
            fail_count_o++;
          end
          if (out_item_i.status !== exp_item.status) begin
            $error("status: expected %0d actual %0d", exp_item.status, out_item_i.status);
            fail_count_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_RES_MASS:   mass_q  <= cfg_data_i;
          CFG_BASE_WIDTH: width_q <= cfg_data_i;
          CFG_BW_NORM:    norm_q  <= cfg_data_i;
          CFG_ORBITAL_L:  orb_l_q <= cfg_data_i[2:0];
          default: ;
        endcase
      end
    end
  end
endmodule

`default_nettype wire

### verif/tb_breit_wigner_evaluator.sv
// ----------------------------------------------------------------------------
// tb_breit_wigner_evaluator: stimulus and verdict for the line shape evaluator
// Directed corner items, then phases of random settings and masses around
// the resonance, with bursty input traffic and a patterned output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_breit_wigner_evaluator;
  timeunit 1ns;
  timeprecision 1ps;

  import bwe_pkg::*;

  localparam int IDLE_LIMIT = 60000;
  localparam logic [31:0] THRESH = 32'd18016974;  // mN + mPi, Q8.24

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_RES_MASS;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  bwe_in_t     in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  bwe_out_t    out_item;
  int          fail_count, pending;
  logic        in_fire_q = 1'b0, cfg_fire_q = 1'b0, any_fire_q = 1'b0;
  int          idle_cycles = 0;
  int          stall_mode = 0, stall_left = 0;
  logic [31:0] cur_mass = RST_RES_MASS;

  always #5 clk = ~clk;

  breit_wigner_evaluator i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_item_o(out_item)
  );

  bwe_line_shape_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_item_i(in_item),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_item_i(out_item),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // handshake flags, read back at the falling edge
  always @(posedge clk) begin
    in_fire_q  <= in_valid && !in_stall;
    cfg_fire_q <= cfg_valid && cfg_ready;
    any_fire_q <= (in_valid && !in_stall) || (cfg_valid && cfg_ready) ||
                  (out_valid && !out_stall);
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if (any_fire_q) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_breit_wigner_evaluator failed");
      $finish;
    end
  end

  // output stall: free, random, or mostly stalled, switching now and then
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(50, 3000);
    end else begin
      stall_left = stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 1) == 1);
      default: out_stall <= ($urandom_range(0, 9) != 0);
    endcase
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(negedge clk); while (!cfg_fire_q);
    cfg_valid = 1'b0;
    if (idx == CFG_RES_MASS) cur_mass = data;
  endtask

  task automatic send(logic func, logic [31:0] w);
    in_valid = 1'b1;
    in_item.func = func;
    in_item.w_mass = w;
    do @(negedge clk); while (!in_fire_q);
    in_valid = 1'b0;
  endtask

  // both directions quiet before touching registers
  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic setup(logic [31:0] m, logic [31:0] g, logic [31:0] n, logic [2:0] l);
    drain();
    write_reg(CFG_RES_MASS, m);
    write_reg(CFG_BASE_WIDTH, g);
    write_reg(CFG_BW_NORM, n);
    write_reg(CFG_ORBITAL_L, 32'(l));
  endtask

  // mostly masses near the resonance, some near threshold, some anywhere, a few zero
  function automatic logic [31:0] pick_mass();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return 32'd0;
    if (sel < 5) return $urandom();
    if (sel < 7) return THRESH + $urandom_range(0, 4) - 2;
    return cur_mass + $urandom_range(0, 32'h00800000) - 32'h00400000;
  endfunction

  initial begin
    int sent;
    int gap;
    logic [31:0] m, g, n;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // defaults: zero, tiny, maximum, on the pole, below and at threshold
    for (int f = 0; f < 2; f++) begin
      send(f[0], 32'd0);
      send(f[0], 32'd1);
      send(f[0], 32'hFFFF_FFFF);
      send(f[0], RST_RES_MASS);
      send(f[0], 32'd16777216);
      send(f[0], THRESH);
    end
    // mass just below threshold: zero reference momentum
    setup(THRESH - 1, 32'd2013266, 32'd16777216, 3'd0);
    send(1'b1, 32'd40000000);
    send(1'b0, 32'd40000000);
    // just above threshold: ratio overflow, high L: width overflow
    setup(THRESH + 1, 32'hFFFF_FFFF, 32'd1, 3'd7);
    send(1'b1, 32'hFFFF_FFFF);
    send(1'b1, 32'd30000000);
    send(1'b0, THRESH + 1);
    // narrow width, tiny norm: result overflow
    setup(32'hFFFF_FFFF, 32'd1, 32'd1, 3'd0);
    send(1'b0, 32'hFFFF_FFFF);
    send(1'b1, 32'hFFFF_FFFE);
    send(1'b0, 32'd1);
    // zero-valued registers are invalid operands
    setup(32'd0, 32'd0, 32'd0, 3'd2);
    send(1'b0, 32'd20000000);
    send(1'b1, 32'd20000000);

    // random phases of settings and traffic
    sent = 0;
    for (int ph = 0; sent < 1650; ph++) begin
      case (ph % 5)
        0: m = $urandom_range(18000000, 80000000);
        1: m = $urandom();
        default: m = $urandom_range(18500000, 40000000);
      endcase
      g = (ph % 4 == 1) ? $urandom() : $urandom_range(1, 32'h0100_0000);
      n = (ph % 3 == 2) ? $urandom() : $urandom_range(1, 32'h0400_0000);
      setup(m, g, n, (ph % 6 == 0) ? 3'd7 : 3'($urandom_range(0, 7)));
      for (int i = 0; i < 150 && sent < 1650; i++) begin
        send($urandom_range(0, 1) == 1, pick_mass());
        sent++;
        if ($urandom_range(0, 3) == 0) begin
          gap = $urandom_range(1, 40);
          repeat (gap) @(negedge clk);
        end
      end
    end

    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_count == 0) $display("tb_breit_wigner_evaluator passed");
    else $display("tb_breit_wigner_evaluator failed");
    $finish;
  end
endmodule

`default_nettype wire

### sim.f
rtl/core/bwe_pkg.sv
rtl/core/bwe_arith.sv
rtl/core/bwe_datapath.sv
rtl/core/bwe_ctrl.sv
rtl/core/breit_wigner_evaluator.sv
verif/bwe_line_shape_checker.sv
verif/tb_breit_wigner_evaluator.sv
